// ===== hdl/sprite_outline_rim_assert.svh =====
// ----------------------------------------------------------------------------
// sprite_outline_rim_assert.svh
// Assertion macros used by the outline rim checker, sor_check.
// ----------------------------------------------------------------------------
`ifndef SPRITE_OUTLINE_RIM_ASSERT_SVH
`define SPRITE_OUTLINE_RIM_ASSERT_SVH

// Same-cycle implication, gated off while dis is high
`define SOR_ASSERT_IMPLY(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("sprite_outline_rim: same-cycle check failed");

// Next-cycle implication, gated off while dis is high
`define SOR_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("sprite_outline_rim: next-cycle check failed");

`endif

// ===== hdl/sor_pkg.sv =====
// ----------------------------------------------------------------------------
// sor_pkg
// Beat types, register map and the solidity test of the outline rim block.
// ----------------------------------------------------------------------------
package sor_pkg;

    // Pixel word and APB geometry
    localparam int unsigned PIX_W  = 32;
    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_IMG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RIM_COLOUR = 2'd2;

    // Register reset values
    localparam logic [6:0]       IMG_WIDTH_RST  = 7'd32;
    localparam logic [6:0]       IMG_HEIGHT_RST = 7'd32;
    localparam logic [PIX_W-1:0] RIM_COLOUR_RST = 32'd255;

    // Input operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] pix_red;
        logic [7:0] pix_green;
        logic [7:0] pix_blue;
        logic [7:0] pix_alpha;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       became_rim;
        logic       frame_end;
    } t_out_beat;

    // Register file view handed to the datapath
    typedef struct packed {
        logic [6:0]       img_width;
        logic [6:0]       img_height;
        logic [PIX_W-1:0] rim_colour;
        logic             restart;
    } t_cfg;

    // Pending pixel leaving the line buffer stage
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pix;
        logic             self_solid;
        logic             nb_part;
        logic             right_en;
        logic             last;
        logic [PIX_W-1:0] right_pix;
    } t_stage;

    // Solid: nonzero alpha and not already the rim colour
    function automatic logic is_solid(logic [PIX_W-1:0] px, logic [PIX_W-1:0] rim);
        return (px[31:24] != 8'd0) && (px != rim);
    endfunction

endpackage

// ===== hdl/sor_ram.sv =====
// ----------------------------------------------------------------------------
// sor_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sor_ram #(
    parameter int unsigned WIDTH = 33,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read; read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sor_cfg.sv =====
// ----------------------------------------------------------------------------
// sor_cfg
// APB register file: image width, image height and rim colour.
// ----------------------------------------------------------------------------
module sor_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sor_pkg::APB_AW-1:0]  paddr,
    input  logic [sor_pkg::APB_DW-1:0]  pwdata,
    output logic [sor_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output sor_pkg::t_cfg               o_cfg
);

    logic [6:0]                  r_width;
    logic [6:0]                  r_height;
    logic [sor_pkg::PIX_W-1:0]   r_rim;
    logic                        wr_en;
    logic                        known_reg;
    logic [1:0]                  reg_idx;

    assign reg_idx   = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign known_reg = (reg_idx == sor_pkg::REG_IMG_WIDTH)
                    || (reg_idx == sor_pkg::REG_IMG_HEIGHT)
                    || (reg_idx == sor_pkg::REG_RIM_COLOUR);

    // Update registers on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sor_pkg::IMG_WIDTH_RST;
            r_height <= sor_pkg::IMG_HEIGHT_RST;
            r_rim    <= sor_pkg::RIM_COLOUR_RST;
        end else if (wr_en) begin
            case (reg_idx)
                sor_pkg::REG_IMG_WIDTH:  r_width  <= pwdata[6:0];
                sor_pkg::REG_IMG_HEIGHT: r_height <= pwdata[6:0];
                sor_pkg::REG_RIM_COLOUR: r_rim    <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            sor_pkg::REG_IMG_WIDTH:  prdata = {25'd0, r_width};
            sor_pkg::REG_IMG_HEIGHT: prdata = {25'd0, r_height};
            sor_pkg::REG_RIM_COLOUR: prdata = r_rim;
            default:                 prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Any write to a known register restarts the frame on the same edge
    assign o_cfg.img_width  = r_width;
    assign o_cfg.img_height = r_height;
    assign o_cfg.rim_colour = r_rim;
    assign o_cfg.restart    = wr_en && known_reg;

endmodule

// ===== hdl/sor_front.sv =====
// ----------------------------------------------------------------------------
// sor_front
// Line buffer stage: raster counters, one-row pixel RAM with solid-above
// flags, read-ahead of the right neighbor and the pending-pixel register.
// ----------------------------------------------------------------------------
module sor_front #(
    parameter int unsigned MAX_WIDTH  = 64,
    parameter int unsigned MAX_HEIGHT = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sor_pkg::t_cfg     i_cfg,
    input  logic              i_accept,
    input  sor_pkg::t_in_beat i_in_data,
    input  logic              i_b_adv,
    output sor_pkg::t_stage   o_stage
);

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned EW = sor_pkg::PIX_W + 1;

    logic [CW-1:0]             used_w;
    logic [RW-1:0]             used_h;
    logic [AW-1:0]             r_col;
    logic [RW-1:0]             r_row;
    logic                      r_left;
    logic                      last_col;
    logic                      draining;
    logic [AW-1:0]             next_addr;
    logic                      is_pix;
    logic                      is_drain;
    logic                      emit;
    logic [sor_pkg::PIX_W-1:0] px;
    logic [EW-1:0]             ram_rdata;
    logic [EW-1:0]             cur;
    logic [EW-1:0]             wr_entry;
    logic                      r_fwd_hit;
    logic [EW-1:0]             r_fwd_data;
    logic                      self_solid;
    logic                      nb_part;
    logic                      r_b_valid;
    logic [sor_pkg::PIX_W-1:0] r_b_pix;
    logic                      r_b_self;
    logic                      r_b_nb;
    logic                      r_b_right_en;
    logic                      r_b_last;

    // Clamp the programmed geometry to the buffer size
    always_comb begin
        if (i_cfg.img_width == 7'd0) begin
            used_w = CW'(1);
        end else if (32'(i_cfg.img_width) > 32'(MAX_WIDTH)) begin
            used_w = CW'(MAX_WIDTH);
        end else begin
            used_w = CW'(i_cfg.img_width);
        end
    end

    always_comb begin
        if (i_cfg.img_height == 7'd0) begin
            used_h = RW'(1);
        end else if (32'(i_cfg.img_height) > 32'(MAX_HEIGHT)) begin
            used_h = RW'(MAX_HEIGHT);
        end else begin
            used_h = RW'(i_cfg.img_height);
        end
    end

    // Position decode; the row counter at the height means drain phase
    assign last_col  = (CW'(r_col) + CW'(1)) == used_w;
    assign draining  = (r_row == used_h);
    assign next_addr = last_col ? '0 : r_col + AW'(1);
    assign is_pix    = i_accept && (i_in_data.op == sor_pkg::OP_PIXEL) && !draining;
    assign is_drain  = i_accept && (i_in_data.op == sor_pkg::OP_DRAIN) && draining;
    assign emit      = (is_pix && (r_row != '0)) || is_drain;

    assign px = {i_in_data.pix_alpha, i_in_data.pix_blue,
                 i_in_data.pix_green, i_in_data.pix_red};

    // Entry at the current column: last read, or the word written over it
    assign cur        = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign self_solid = sor_pkg::is_solid(cur[sor_pkg::PIX_W-1:0], i_cfg.rim_colour);
    assign wr_entry   = {self_solid, px};

    // Neighbors known at accept: left, above, and below (the incoming pixel)
    always_comb begin
        if (is_pix) begin
            nb_part = ((r_col != '0) && r_left)
                   || ((r_row > RW'(1)) && cur[EW-1])
                   || sor_pkg::is_solid(px, i_cfg.rim_colour);
        end else begin
            nb_part = ((r_col != '0) && r_left)
                   || ((used_h != RW'(1)) && cur[EW-1]);
        end
    end

    sor_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (is_pix),
        .i_waddr (r_col),
        .i_wdata (wr_entry),
        .i_re    (is_pix || is_drain),
        .i_raddr (next_addr),
        .o_rdata (ram_rdata)
    );

    // Forward a write that lands on the address read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (is_pix || is_drain) begin
            r_fwd_hit <= is_pix && (next_addr == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_pix) begin
            r_fwd_data <= wr_entry;
        end
    end

    // Advance raster counters; a register write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= 1'b0;
        end else begin
            if (emit) begin
                r_left <= self_solid;
            end
            if (is_pix) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= r_row + RW'(1);
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end else if (is_drain) begin
                if (last_col) begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_left <= 1'b0;
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end
        end
    end

    // Pending pixel register; drop it when it moves to the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_accept) begin
            r_b_valid <= emit;
        end else if (i_b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_b_pix      <= cur[sor_pkg::PIX_W-1:0];
            r_b_self     <= self_solid;
            r_b_nb       <= nb_part;
            r_b_right_en <= !last_col;
            r_b_last     <= is_drain && last_col;
        end
    end

    // Right neighbor is the read-ahead entry, read at the accept that loads the pending pixel
    assign o_stage.valid      = r_b_valid;
    assign o_stage.pix        = r_b_pix;
    assign o_stage.self_solid = r_b_self;
    assign o_stage.nb_part    = r_b_nb;
    assign o_stage.right_en   = r_b_right_en;
    assign o_stage.last       = r_b_last;
    assign o_stage.right_pix  = cur[sor_pkg::PIX_W-1:0];

endmodule

// ===== hdl/sprite_outline_rim.sv =====
// ----------------------------------------------------------------------------
// sprite_outline_rim
// Four-neighbor outline dilation of a streamed RGBA image.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes pixels in raster
//   order, op = pixel. After the last pixel send one drain beat per column.
//   Output channel (o_out_valid / i_out_ready / o_out_data) gives one beat per
//   pixel of the row above the incoming one; the first row gives none, and
//   the drain beats flush the last row, frame_end marking its final pixel.
//   Pixel beats during the drain and drain beats outside it are taken and
//   dropped. A result passes the pending stage, then the output register.
//   Throughput is one beat per cycle while the receiver does not stall, set
//   by the line buffer RAM, which does one read-ahead and one write per beat.
//   Registers (APB): 0x0 width, 0x4 height, 0x8 rim colour. A write to one
//   of them restarts the frame; write only while the block is idle.
//   Reset returns the registers to 32 x 32 with rim 0x000000FF and empties
//   both stages; no clearing pass is needed. While the receiver stalls the
//   output beat holds and one more result can wait in the pending stage,
//   after which o_in_ready drops.
// ----------------------------------------------------------------------------
module sprite_outline_rim #(
    parameter int unsigned MAX_WIDTH  = 64,
    parameter int unsigned MAX_HEIGHT = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sor_pkg::APB_AW-1:0] paddr,
    input  logic [sor_pkg::APB_DW-1:0] pwdata,
    output logic [sor_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    input  sor_pkg::t_in_beat          i_in_data,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    output sor_pkg::t_out_beat         o_out_data,
    input  logic                       i_out_ready
);

    sor_pkg::t_cfg             cfg;
    sor_pkg::t_stage           stage;
    logic                      out_free;
    logic                      accept;
    logic                      b_adv;
    logic                      rim_sel;
    logic [sor_pkg::PIX_W-1:0] px_out;
    logic                      r_out_valid;
    sor_pkg::t_out_beat        r_out_data;

    sor_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshake: the pending stage keeps input open while the output stalls, until it fills
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = !stage.valid || out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign b_adv      = stage.valid && out_free;

    sor_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_accept  (accept),
        .i_in_data (i_in_data),
        .i_b_adv   (b_adv),
        .o_stage   (stage)
    );

    // Finish the neighbor test with the right pixel and pick the color
    assign rim_sel = !stage.self_solid
                  && (stage.nb_part
                      || (stage.right_en
                          && sor_pkg::is_solid(stage.right_pix, cfg.rim_colour)));
    assign px_out  = rim_sel ? cfg.rim_colour : stage.pix;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_out_data.out_red    <= px_out[7:0];
            r_out_data.out_green  <= px_out[15:8];
            r_out_data.out_blue   <= px_out[23:16];
            r_out_data.out_alpha  <= px_out[31:24];
            r_out_data.became_rim <= rim_sel;
            r_out_data.frame_end  <= stage.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hdl/sor_check.sv =====
// ----------------------------------------------------------------------------
// sor_check
// Port-level checks of the outline rim block, bound to its top level.
// ----------------------------------------------------------------------------
`include "sprite_outline_rim_assert.svh"

module sor_check (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       pready,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input sor_pkg::t_out_beat         o_out_data,
    input logic                       i_out_ready
);

    // Hold a stalled output beat
    `SOR_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // An empty output register never blocks the input
    `SOR_ASSERT_IMPLY(a_in_open, i_clk, !i_rst_n, !o_out_valid, o_in_ready)

    // Reset empties the output
    `SOR_ASSERT_NEXT(a_rst_empty, i_clk, 1'b0, !i_rst_n, !o_out_valid)

    // APB never waits, even with the stream stalled
    `SOR_ASSERT_IMPLY(a_apb_ready, i_clk, !i_rst_n, i_in_valid && !o_in_ready, pready)

endmodule

bind sprite_outline_rim sor_check u_sor_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .pready      (pready),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_ready (i_out_ready)
);
